// File: sv/fmgps_pkg.sv
// ----------------------------------------------------------------------------
// fmgps_pkg
// Shared constants, types and helper functions of the FASTA pattern scanner.
// ----------------------------------------------------------------------------
package fmgps_pkg;

	localparam int NUM_PATTERNS = 5;
	localparam int PATTERN_LEN  = 36;
	localparam int WIN_W        = 2 * PATTERN_LEN;
	localparam int RUN_W        = $clog2(PATTERN_LEN + 1);
	localparam int Q_DEPTH      = 4;
	localparam int Q_AW         = $clog2(Q_DEPTH);
	localparam int Q_CW         = $clog2(Q_DEPTH + 1);

	// special bytes of the file format
	localparam logic [7:0] CH_HEADER = 8'h3E;  // '>'
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFS  = 8'h20;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_T      = 8'h54;

	// base codes
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	// operation kinds handed from front to back
	localparam logic [1:0] OP_BASE  = 2'd0;
	localparam logic [1:0] OP_OTHER = 2'd1;
	localparam logic [1:0] OP_EOF   = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic       brk;   // a run of blanks came before this byte
		logic [1:0] code;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} push_t;

	// base code of an upper-case byte; valid flag low for anything else
	function automatic logic [2:0] base_lookup(input logic [7:0] c);
		logic [2:0] r;
		unique case (c)
			CH_A:    r = {1'b1, BASE_A};
			CH_C:    r = {1'b1, BASE_C};
			CH_G:    r = {1'b1, BASE_G};
			CH_T:    r = {1'b1, BASE_T};
			default: r = {1'b0, BASE_A};
		endcase
		return r;
	endfunction

	// pack a pattern string into window layout: base k at bits [2k+1:2k]
	function automatic logic [WIN_W-1:0] pat_vec(input logic [8*PATTERN_LEN-1:0] s);
		logic [WIN_W-1:0] v;
		logic [2:0]       b;
		v = '0;
		for (int k = 0; k < PATTERN_LEN; k++) begin
			b = base_lookup(s[8*(PATTERN_LEN-1-k) +: 8]);
			v[2*k +: 2] = b[1:0];
		end
		return v;
	endfunction

	localparam logic [WIN_W-1:0] PAT_TABLE [NUM_PATTERNS] = '{
		pat_vec("ATGAGTATTCAACATTTCCGTGTCGCCCTTATTCCC"),
		pat_vec("ATGAAAAAGATAGAAATTTCTTCAGTATTCAAAGAA"),
		pat_vec("ATGCGTTATATTCGCCTGTGTATTATCTCCCTGTGA"),
		pat_vec("ATGGCAAAGACAGCTATGACCATGATTACGCCAAGC"),
		pat_vec("ATGATTGAACAAGATGGATTGCACGCAGGTTCTCCG")
	};

endpackage

// File: sv/fmgps_front.sv
// ----------------------------------------------------------------------------
// fmgps_front
// Line parser: drops headers, line feeds and blanks, flags a blank run on the
// next kept byte, folds case and turns kept bytes and end of file into operations.
// ----------------------------------------------------------------------------
module fmgps_front import fmgps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,         // a word is accepted this cycle
	input  logic [7:0] char_code,
	input  logic       end_of_file,
	output push_t      push
);

	logic       at_line_start_q;
	logic       in_header_q;
	logic       pending_blank_q;

	logic       hdr;
	logic       is_blank;
	logic [7:0] upper;
	logic [2:0] lookup;

	// classify the incoming byte
	always_comb begin
		hdr      = in_header_q | (at_line_start_q & (char_code == CH_HEADER));
		is_blank = (char_code == CH_CR) | (char_code == CH_SPACE);
		upper    = ((char_code >= CH_LOW_A) && (char_code <= CH_LOW_Z)) ?
		           (char_code - CASE_OFS) : char_code;
		lookup   = base_lookup(upper);

		push.valid   = 1'b0;
		push.op.kind = OP_OTHER;
		push.op.brk  = pending_blank_q;
		push.op.code = lookup[1:0];
		if (end_of_file) begin
			push.valid   = take;
			push.op.kind = OP_EOF;
		end else if ((char_code != CH_LF) && !hdr && !is_blank) begin
			push.valid   = take;
			push.op.kind = lookup[2] ? OP_BASE : OP_OTHER;
		end
	end

	// track line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q <= 1'b1;
			in_header_q     <= 1'b0;
			pending_blank_q <= 1'b0;
		end else if (take) begin
			if (end_of_file || (char_code == CH_LF)) begin
				at_line_start_q <= 1'b1;
				in_header_q     <= 1'b0;
				pending_blank_q <= 1'b0;
			end else begin
				at_line_start_q <= 1'b0;
				in_header_q     <= hdr;
				if (!hdr) begin
					pending_blank_q <= is_blank;
				end
			end
		end
	end

endmodule

// File: sv/fmgps_queue.sv
// ----------------------------------------------------------------------------
// fmgps_queue
// Small operation FIFO between the parser and the matcher.
// ----------------------------------------------------------------------------
module fmgps_queue import fmgps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  full,
	output logic  avail,
	input  logic  pop,
	output op_t   head
);

	op_t              entry_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_CW-1:0]  count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == Q_CW'(Q_DEPTH));
	assign avail   = (count_q != '0);
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push.valid & ~full;
	assign do_pop  = pop & avail;

	// store the operation
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.op;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/fmgps_back.sv
// ----------------------------------------------------------------------------
// fmgps_back
// Matcher: shifts bases into the window, counts the base run, compares the
// window with every pattern and delivers the summary word at end of file.
// ----------------------------------------------------------------------------
module fmgps_back import fmgps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       avail,
	input  op_t        head,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [4:0] present_bits, [5] empty_genome, [7:6] zero
);

	logic [WIN_W-1:0]        window_q;
	logic [RUN_W-1:0]        run_length_q;
	logic [NUM_PATTERNS-1:0] found_bits_q;
	logic                    seen_sequence_q;
	logic                    out_valid_q;
	logic [4:0]              out_present_q;
	logic                    out_empty_q;

	logic                    slot_free;
	logic [RUN_W-1:0]        run_base;
	logic [RUN_W-1:0]        run_next;
	logic [WIN_W-1:0]        win_next;
	logic [NUM_PATTERNS-1:0] hit;
	logic [4:0]              found_out;

	assign slot_free = ~out_valid_q | m_tready;
	assign pop       = avail & ((head.kind != OP_EOF) | slot_free);

	// next window, run and pattern hits
	always_comb begin
		run_base = head.brk ? '0 : run_length_q;
		run_next = (run_base < RUN_W'(PATTERN_LEN)) ? (run_base + 1'b1) : run_base;
		win_next = {head.code, window_q[WIN_W-1:2]};
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			hit[p] = (win_next == PAT_TABLE[p]) && (run_next >= RUN_W'(PATTERN_LEN));
		end
		found_out = '0;
		found_out[NUM_PATTERNS-1:0] = found_bits_q;
	end

	// shift the window
	always_ff @(posedge clk) begin
		if (pop && (head.kind == OP_BASE)) begin
			window_q <= win_next;
		end
	end

	// hold the result word
	always_ff @(posedge clk) begin
		if (pop && (head.kind == OP_EOF)) begin
			out_present_q <= found_out;
			out_empty_q   <= ~seen_sequence_q;
		end
	end

	// update scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q    <= '0;
			found_bits_q    <= '0;
			seen_sequence_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			// drop the word once taken, load a new one at end of file
			out_valid_q <= (out_valid_q & ~m_tready) | (pop & (head.kind == OP_EOF));
			if (pop) begin
				unique case (head.kind)
					OP_BASE: begin
						seen_sequence_q <= 1'b1;
						run_length_q    <= run_next;
						found_bits_q    <= found_bits_q | hit;
					end
					OP_OTHER: begin
						seen_sequence_q <= 1'b1;
						run_length_q    <= '0;
					end
					OP_EOF: begin
						seen_sequence_q <= 1'b0;
						run_length_q    <= '0;
						found_bits_q    <= '0;
					end
					default: begin
						run_length_q <= run_length_q;
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_empty_q, out_present_q};

endmodule

// File: sv/fasta_multi_gene_pattern_scanner_core.sv
// ----------------------------------------------------------------------------
// fasta_multi_gene_pattern_scanner_core
// Scans a FASTA byte stream for five fixed 36-base genes.
// ----------------------------------------------------------------------------
// Feed the file one byte per word on the slave side and mark the end of the
// file with a word whose tlast is high (its byte is ignored). The block takes
// one byte per clock: a parser drops header lines, line feeds and blanks and
// folds case, then a four-entry queue hands each kept byte to the matcher,
// which shifts each base into a 36-base window and compares all patterns in
// the same cycle. The only result is one master-side word per file, registered
// when the matcher takes the end-of-file word; the input stalls only while
// the queue is full, which happens when that result word waits to be taken
// and a second end-of-file word is queued behind it. State clears after each
// file, so files can follow back to back.
module fasta_multi_gene_pattern_scanner_core import fmgps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tlast,   // end_of_file
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [4:0] present_bits, [5] empty_genome, [7:6] zero
);

	push_t push;
	op_t   head;
	logic  full;
	logic  avail;
	logic  pop;

	assign s_tready = ~full;

	// parse and classify bytes
	fmgps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (s_tvalid & ~full),
		.char_code   (s_tdata),
		.end_of_file (s_tlast),
		.push        (push)
	);

	// decouple parser from matcher
	fmgps_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.avail  (avail),
		.pop    (pop),
		.head   (head)
	);

	// match and report
	fmgps_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.avail    (avail),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: bench/fmgps_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmgps_scan_checker
// Watches both streams of the FASTA scanner, predicts the result word of each
// file from the accepted input words and compares every result word with it.
// ----------------------------------------------------------------------------

// gene table shared by the checker and the stimulus
package fmgps_tb_pkg;
	import fmgps_pkg::*;

	// upper-case letter at position pos of gene number gene
	function automatic logic [7:0] gene_base(input int unsigned gene, input int unsigned pos);
		logic [8*PATTERN_LEN-1:0] letters;
		case (gene)
			0:       letters = "ATGAGTATTCAACATTTCCGTGTCGCCCTTATTCCC";
			1:       letters = "ATGAAAAAGATAGAAATTTCTTCAGTATTCAAAGAA";
			2:       letters = "ATGCGTTATATTCGCCTGTGTATTATCTCCCTGTGA";
			3:       letters = "ATGGCAAAGACAGCTATGACCATGATTACGCCAAGC";
			default: letters = "ATGATTGAACAAGATGGATTGCACGCAGGTTCTCCG";
		endcase
		return letters[8*(PATTERN_LEN-1-pos) +: 8];
	endfunction

endpackage

module fmgps_scan_checker import fmgps_pkg::*; import fmgps_tb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	input  logic [7:0]              s_tdata,
	input  logic                    s_tlast,
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic [7:0]              m_tdata,
	output int                      mismatches,
	output int                      awaiting,
	output int                      results_seen,
	output logic [NUM_PATTERNS-1:0] genes_hit
);

	typedef struct packed {
		logic [NUM_PATTERNS-1:0] present;
		logic                    empty;
	} scan_result_t;

	scan_result_t expected_scans[$];

	// predicted scanner state
	logic [1:0]              window [PATTERN_LEN];
	logic [RUN_W-1:0]        run_len;
	logic                    line_start;
	logic                    in_header;
	logic                    blank_pending;
	logic                    seen_seq;
	logic [NUM_PATTERNS-1:0] found;

	// valid flag and 2-bit code of an upper-case letter
	function automatic logic [2:0] code_of(input logic [7:0] ch);
		case (ch)
			CH_A:    return {1'b1, BASE_A};
			CH_C:    return {1'b1, BASE_C};
			CH_G:    return {1'b1, BASE_G};
			CH_T:    return {1'b1, BASE_T};
			default: return 3'b000;
		endcase
	endfunction

	task automatic clear_scan();
		foreach (window[k]) window[k] = BASE_A;
		run_len       = '0;
		line_start    = 1'b1;
		in_header     = 1'b0;
		blank_pending = 1'b0;
		seen_seq      = 1'b0;
		found         = '0;
	endtask

	// compare the full window with every gene
	task automatic match_genes();
		logic hit;
		for (int g = 0; g < NUM_PATTERNS; g++) begin
			hit = 1'b1;
			for (int k = 0; k < PATTERN_LEN; k++) begin
				if (code_of(gene_base(g, k)) != {1'b1, window[k]})
					hit = 1'b0;
			end
			if (hit)
				found[g] = 1'b1;
		end
	endtask

	// advance the prediction by one file byte
	task automatic take_byte(input logic [7:0] ch);
		logic [2:0] code;
		if (ch == CH_LF) begin
			line_start    = 1'b1;
			in_header     = 1'b0;
			blank_pending = 1'b0;
		end else if (line_start && ch == CH_HEADER) begin
			line_start = 1'b0;
			in_header  = 1'b1;
		end else begin
			line_start = 1'b0;
			if (!in_header) begin
				if (ch == CH_CR || ch == CH_SPACE) begin
					blank_pending = 1'b1;
				end else begin
					// blanks followed by text become sequence and break the run
					if (blank_pending) begin
						blank_pending = 1'b0;
						run_len       = '0;
					end
					seen_seq = 1'b1;
					if (ch >= CH_LOW_A && ch <= CH_LOW_Z)
						ch = ch - CASE_OFS;
					code = code_of(ch);
					if (!code[2]) begin
						run_len = '0;
					end else begin
						for (int k = 0; k < PATTERN_LEN - 1; k++)
							window[k] = window[k + 1];
						window[PATTERN_LEN - 1] = code[1:0];
						if (run_len < PATTERN_LEN)
							run_len++;
						if (run_len == PATTERN_LEN)
							match_genes();
					end
				end
			end
		end
	endtask

	// check result words first, then fold in the input word of the same edge
	always @(posedge clk or negedge arst_n) begin : watch
		scan_result_t want;
		if (!arst_n) begin
			clear_scan();
			expected_scans.delete();
			awaiting     = 0;
			mismatches   = 0;
			results_seen = 0;
			genes_hit    = '0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_scans.size() == 0) begin
					$error("result word %02h arrived with no result expected", m_tdata);
					mismatches++;
				end else begin
					want = expected_scans.pop_front();
					results_seen++;
					if (m_tdata[NUM_PATTERNS-1:0] !== want.present) begin
						$error("present_bits: expected %05b, got %05b",
							want.present, m_tdata[NUM_PATTERNS-1:0]);
						mismatches++;
					end
					if (m_tdata[NUM_PATTERNS] !== want.empty) begin
						$error("empty_genome: expected %0b, got %0b",
							want.empty, m_tdata[NUM_PATTERNS]);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tlast) begin
					expected_scans.push_back('{present: found, empty: !seen_seq});
					genes_hit = genes_hit | found;
					clear_scan();
				end else begin
					take_byte(s_tdata);
				end
			end
			awaiting = expected_scans.size();
		end
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives FASTA files into the pattern scanner: a short directed file set,
// then random genome files carrying whole or damaged genes and noise files,
// under changing input gaps and output stalls. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
	import fmgps_pkg::*;
	import fmgps_tb_pkg::*;

	localparam int ITEM_GOAL  = 1350;
	localparam int FILE_GOAL  = 40;
	localparam int HOLD_LEN   = 400;
	localparam int TAIL_LEN   = 20;
	localparam int TIMEOUT_NS = 2_000_000;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_ask       = 0;
	int hold_done      = 0;
	int bytes_sent     = 0;
	int files_sent     = 0;

	int                      mismatches;
	int                      awaiting;
	int                      results_seen;
	logic [NUM_PATTERNS-1:0] genes_hit;

	logic [7:0] file_bytes[$];

	always #4 clk = ~clk;

	fasta_multi_gene_pattern_scanner_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	fmgps_scan_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.mismatches   (mismatches),
		.awaiting     (awaiting),
		.results_seen (results_seen),
		.genes_hit    (genes_hit)
	);

	// offer one word, with random gaps before it; return at the next falling edge
	task automatic put_word(input logic [7:0] data, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (!last)
			bytes_sent++;
	endtask

	// stop offering and hold until every expected result word has been taken
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (awaiting != 0);
	endtask

	// send the buffered file, then its end-of-file word with a junk byte
	task automatic send_file();
		foreach (file_bytes[i])
			put_word(file_bytes[i], 1'b0);
		put_word(8'($urandom_range(0, 255)), 1'b1);
		files_sent++;
		file_bytes.delete();
	endtask

	function automatic logic [7:0] rand_base();
		case ($urandom_range(0, 3))
			0:       return CH_A;
			1:       return CH_C;
			2:       return CH_G;
			default: return CH_T;
		endcase
	endfunction

	// append a base, sometimes lower case, sometimes followed by a line break, a blank or an N
	task automatic emit_base(input logic [7:0] ch);
		int roll;
		if ($urandom_range(0, 3) == 0)
			ch = ch + CASE_OFS;
		file_bytes.push_back(ch);
		roll = $urandom_range(0, 199);
		if (roll < 12) begin
			// trailing blanks are dropped, so the run carries over the break
			repeat ($urandom_range(0, 2))
				file_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_SPACE);
			file_bytes.push_back(CH_LF);
		end else if (roll == 12) begin
			file_bytes.push_back(CH_SPACE);
		end else if (roll == 13) begin
			file_bytes.push_back("N");
		end
	endtask

	// append a gene, with one base changed when damaged
	task automatic emit_gene(input int unsigned gene, input logic damaged);
		int         spot;
		logic [7:0] ch;
		spot = damaged ? int'($urandom_range(0, PATTERN_LEN - 1)) : -1;
		for (int k = 0; k < PATTERN_LEN; k++) begin
			ch = gene_base(gene, k);
			if (k == spot) begin
				while (ch == gene_base(gene, k))
					ch = rand_base();
			end
			emit_base(ch);
		end
	endtask

	task automatic add_header();
		logic [7:0] ch;
		file_bytes.push_back(CH_HEADER);
		repeat ($urandom_range(0, 12)) begin
			ch = 8'($urandom_range(0, 255));
			if (ch == CH_LF)
				ch = CH_A;
			file_bytes.push_back(ch);
		end
		file_bytes.push_back(CH_LF);
	endtask

	task automatic build_genome_file();
		if ($urandom_range(0, 1))
			add_header();
		repeat ($urandom_range(0, 12))
			emit_base(rand_base());
		repeat ($urandom_range(1, 3)) begin
			emit_gene($urandom_range(0, NUM_PATTERNS - 1), $urandom_range(0, 99) < 15);
			repeat ($urandom_range(0, 8))
				emit_base(rand_base());
			if ($urandom_range(0, 99) < 10) begin
				file_bytes.push_back(CH_LF);
				add_header();
			end
		end
		if ($urandom_range(0, 1))
			file_bytes.push_back(CH_CR);
		file_bytes.push_back(CH_LF);
	endtask

	// short files of arbitrary bytes, weighted toward the format's special bytes
	task automatic build_noise_file(input int unsigned max_len);
		repeat ($urandom_range(0, max_len)) begin
			case ($urandom_range(0, 9))
				0:       file_bytes.push_back(CH_LF);
				1:       file_bytes.push_back(CH_CR);
				2:       file_bytes.push_back(CH_SPACE);
				3:       file_bytes.push_back(CH_HEADER);
				4:       file_bytes.push_back(rand_base() + CASE_OFS);
				default: file_bytes.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// stall the output for a long stretch while short files keep arriving
	task automatic crowd_output();
		drain_results();
		hold_ask <= hold_ask + 1;
		repeat (8) begin
			build_noise_file(2);
			send_file();
		end
		drain_results();
	endtask

	// output ready: random stalls, or a long hold when asked
	initial begin
		forever begin
			@(negedge clk);
			if (hold_ask != hold_done) begin
				hold_done = hold_ask;
				m_tready <= 1'b0;
				repeat (HOLD_LEN) @(negedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAIL fasta_multi_gene_pattern_scanner_core");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int last_phase;
		last_phase = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// header, blanks inside and at the end of lines, case folding, byte extremes
		file_bytes = '{CH_HEADER, "q", CH_LF, "a", CH_CR, "c", CH_SPACE, "g", CH_LF,
			8'h00, 8'hFF, 8'h7A, 8'h60, 8'h7B, "t", CH_CR, CH_SPACE, CH_LF};
		send_file();
		// empty file, then a file of a header line and trailing blanks only
		send_file();
		file_bytes = '{CH_HEADER, CH_LF, CH_SPACE, CH_CR};
		send_file();
		drain_results();

		// random files; change the idle mix every five files
		while (bytes_sent < ITEM_GOAL || files_sent < FILE_GOAL) begin
			phase = (files_sent / 5) % 4;
			if (phase != last_phase) begin
				drain_results();
				case (phase)
					0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
					1: begin send_idle_pct = 59; recv_stall_pct <= 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct <= 59; end
					default: begin send_idle_pct = 22; recv_stall_pct <= 22; end
				endcase
				last_phase = phase;
			end
			if (files_sent == 14 || files_sent == 34)
				crowd_output();
			if ($urandom_range(0, 99) < 45)
				build_genome_file();
			else
				build_noise_file(20);
			send_file();
		end

		drain_results();
		repeat (TAIL_LEN) @(negedge clk);

		$display("Sent %0d file bytes in %0d files under four idle mixes and long output holds;",
			bytes_sent, files_sent);
		$display("checked %0d result words, genes found across files: %05b.",
			results_seen, genes_hit);
		if (mismatches == 0 && awaiting == 0)
			$display("PASS fasta_multi_gene_pattern_scanner_core");
		else
			$display("FAIL fasta_multi_gene_pattern_scanner_core");
		$finish;
	end

endmodule
